>>> rtl/token_bucket_rate_limiter_macros.svh
// Assertion macros shared by the token bucket rate limiter RTL.
`ifndef TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH
`define TOKEN_BUCKET_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TBRL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbrl assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TBRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbrl assertion failed");

`endif

>>> rtl/tbrl_pkg.sv
// Package: widths, codes, reset values and control types of the rate limiter.
package tbrl_pkg;

  localparam int FRAC_BITS = 24;
  localparam int LEVEL_W   = 48;
  localparam int TIME_W    = 48;
  localparam int RATE_W    = 32;
  localparam int REQ_W     = 16;
  localparam int CMD_W     = 2;
  localparam int RETRY_W   = 32;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 1;

  // shared unit width: level plus a full elapsed-times-rate product, plus carry room
  localparam int ALU_W     = LEVEL_W + RATE_W + 1;
  localparam int MCAND_W   = ALU_W - 1;
  localparam int NEED_W    = REQ_W + FRAC_BITS;

  localparam int MUL_STEPS = RATE_W;
  localparam int DIV_STEPS = NEED_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] ONE_TOKEN   = LEVEL_W'(64'd1 << FRAC_BITS);
  localparam logic [LEVEL_W-1:0] BURST_MIN   = LEVEL_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [LEVEL_W-1:0] BURST_RESET = LEVEL_W'(64'd10 << FRAC_BITS);
  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'((64'd1 << FRAC_BITS) / 64'd1000);
  localparam logic [RETRY_W-1:0] NO_RATE_WAIT_MS = RETRY_W'(60000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_SIZE  = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CONSUME  = 2'd0,
    CMD_COOLDOWN = 2'd1,
    CMD_REFILL   = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_MUL,
    ST_CAP,
    ST_COOL,
    ST_NEED,
    ST_TAKE,
    ST_DIV,
    ST_OUT
  } state_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic alu_borrow;
    logic alu_zero;
    logic cool_active;
    logic rate_zero;
  } stat_t;

  // sequencer controls seen by the datapath
  typedef struct packed {
    state_t state;
    logic   last_step;
  } ctrl_t;

endpackage

>>> rtl/tbrl_in_if.sv
// Interface: request channel carrying one command beat.
interface tbrl_in_if;
  logic                           valid;
  logic                           ready;
  logic [tbrl_pkg::CMD_W-1:0]     cmd;
  logic [tbrl_pkg::TIME_W-1:0]    now_ms;
  logic [tbrl_pkg::REQ_W-1:0]     request_tokens;
  logic [tbrl_pkg::TIME_W-1:0]    until_ms;

  modport source (output valid, cmd, now_ms, request_tokens, until_ms, input ready);
  modport sink   (input valid, cmd, now_ms, request_tokens, until_ms, output ready);
endinterface

>>> rtl/tbrl_out_if.sv
// Interface: result channel carrying one decision beat.
interface tbrl_out_if;
  logic                           valid;
  logic                           ready;
  logic                           granted;
  logic [tbrl_pkg::RETRY_W-1:0]   retry_after_ms;
  logic [tbrl_pkg::LEVEL_W-1:0]   level_now;

  modport source (output valid, granted, retry_after_ms, level_now, input ready);
  modport sink   (input valid, granted, retry_after_ms, level_now, output ready);
endinterface

>>> rtl/tbrl_alu.sv
// Shared add/subtract unit with borrow and zero flags.
module tbrl_alu (
  input  logic [tbrl_pkg::ALU_W-1:0] a,
  input  logic [tbrl_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output logic [tbrl_pkg::ALU_W-1:0] res,
  output logic                       borrow,
  output logic                       zero
);

  logic [tbrl_pkg::ALU_W:0] sum;

  // add, or subtract as a plus inverted b plus one
  always_comb begin
    sum    = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{tbrl_pkg::ALU_W{1'b0}}, sub};
    res    = sum[tbrl_pkg::ALU_W-1:0];
    borrow = sub & ~sum[tbrl_pkg::ALU_W];
    zero   = (sum[tbrl_pkg::ALU_W-1:0] == '0);
  end

endmodule

>>> rtl/tbrl_fsm.sv
// Sequencer: walks one command through the shared unit, step by step.
module tbrl_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  tbrl_pkg::cmd_t     in_cmd,
  input  logic               out_ready,
  input  tbrl_pkg::stat_t    stat,
  output tbrl_pkg::ctrl_t    ctrl
);

  tbrl_pkg::state_t           state;
  tbrl_pkg::state_t           state_next;
  logic [tbrl_pkg::CNT_W-1:0] cnt;
  logic [tbrl_pkg::CNT_W-1:0] cnt_next;
  logic                       last_step;

  // flag the final iteration of the multiply and divide loops
  always_comb begin
    last_step = 1'b0;
    case (state)
      tbrl_pkg::ST_MUL: last_step = (cnt == tbrl_pkg::CNT_W'(tbrl_pkg::MUL_STEPS - 1));
      tbrl_pkg::ST_DIV: last_step = (cnt == tbrl_pkg::CNT_W'(tbrl_pkg::DIV_STEPS - 1));
      default:          last_step = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tbrl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == tbrl_pkg::CMD_CONSUME) state_next = tbrl_pkg::ST_ELAPSED;
          else                                 state_next = tbrl_pkg::ST_OUT;
        end
      end
      tbrl_pkg::ST_ELAPSED: state_next = tbrl_pkg::ST_MUL;
      tbrl_pkg::ST_MUL: begin
        if (last_step) state_next = tbrl_pkg::ST_CAP;
      end
      tbrl_pkg::ST_CAP: state_next = tbrl_pkg::ST_COOL;
      tbrl_pkg::ST_COOL: begin
        // deadline still ahead of now: deny
        if (stat.cool_active && !stat.alu_borrow && !stat.alu_zero) begin
          state_next = tbrl_pkg::ST_OUT;
        end else begin
          state_next = tbrl_pkg::ST_NEED;
        end
      end
      tbrl_pkg::ST_NEED: begin
        // need minus level: no borrow and nonzero means a deficit
        if (stat.alu_borrow || stat.alu_zero) state_next = tbrl_pkg::ST_TAKE;
        else if (stat.rate_zero)              state_next = tbrl_pkg::ST_OUT;
        else                                  state_next = tbrl_pkg::ST_DIV;
      end
      tbrl_pkg::ST_TAKE: state_next = tbrl_pkg::ST_OUT;
      tbrl_pkg::ST_DIV: begin
        if (last_step) state_next = tbrl_pkg::ST_OUT;
      end
      tbrl_pkg::ST_OUT: begin
        if (out_ready) state_next = tbrl_pkg::ST_IDLE;
      end
      default: state_next = tbrl_pkg::ST_IDLE;
    endcase
  end

  // step counter: advance inside a loop, clear elsewhere
  always_comb begin
    cnt_next = '0;
    if ((state == tbrl_pkg::ST_MUL || state == tbrl_pkg::ST_DIV) && !last_step) begin
      cnt_next = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbrl_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // outputs
  always_comb begin
    ctrl.state     = state;
    ctrl.last_step = last_step;
  end

endmodule

>>> rtl/token_bucket_rate_limiter.sv
// Token bucket rate limiter top level: registers, datapath and the shared unit.
//
// Token bucket policer with a cooldown deadline. Levels are in units of 2^-24
// token. A command beat is taken only while the sequencer is idle; one item
// then runs through a sequencer that reuses a single 81-bit add/subtract unit.
// Set-cooldown, refill and unused commands raise their result beat in the
// cycle after acceptance, so it can be taken at the next rising edge.
// A consume first computes the elapsed time, then multiplies it by the refill
// rate in 32 shift-add steps, caps the level at burst and checks the cooldown.
// Its result beat is raised after the cooldown check when a cooldown holds it
// off, after the deficit check when denied with a zero refill rate, after the
// tokens are taken when granted, and, when denied with a nonzero rate, after
// 40 restoring steps divide the deficit by the rate.
// The next command is accepted the cycle after the result beat is taken.
// Configuration writes through cfg_write/cfg_index/cfg_data take effect at
// once and must be issued only while the block is idle.
module token_bucket_rate_limiter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbrl_pkg::CFG_W-1:0]      cfg_data,
  tbrl_in_if.sink                         item,
  tbrl_out_if.source                      result
);

  `include "token_bucket_rate_limiter_macros.svh"

  // configuration and bucket state
  logic [tbrl_pkg::RATE_W-1:0]   rate;
  logic [tbrl_pkg::LEVEL_W-1:0]  burst;
  logic [tbrl_pkg::LEVEL_W-1:0]  level;
  logic [tbrl_pkg::TIME_W-1:0]   last_time;
  logic                          time_known;
  logic                          cool_active;
  logic [tbrl_pkg::TIME_W-1:0]   deadline;

  // per-item working registers
  logic [tbrl_pkg::TIME_W-1:0]   now_q;
  logic [tbrl_pkg::NEED_W-1:0]   need_q;
  logic [tbrl_pkg::ALU_W-1:0]    acc;
  logic [tbrl_pkg::MCAND_W-1:0]  mcand;
  logic [tbrl_pkg::RATE_W-1:0]   mult;
  logic [tbrl_pkg::RATE_W-1:0]   rem;
  logic [tbrl_pkg::NEED_W-1:0]   dvd;
  logic                          granted_q;
  logic [tbrl_pkg::RETRY_W-1:0]  retry_q;

  logic [tbrl_pkg::ALU_W-1:0]    alu_a;
  logic [tbrl_pkg::ALU_W-1:0]    alu_b;
  logic                          alu_sub;
  logic [tbrl_pkg::ALU_W-1:0]    alu_res;
  logic                          alu_borrow;
  logic                          alu_zero;

  logic [tbrl_pkg::RATE_W:0]     trial;
  logic [tbrl_pkg::NEED_W-1:0]   quot;
  logic [tbrl_pkg::LEVEL_W-1:0]  burst_wr;
  logic                          item_fire;
  logic                          is_consume;
  tbrl_pkg::cmd_t                item_cmd;
  tbrl_pkg::stat_t               stat;
  tbrl_pkg::ctrl_t               ctrl;

  assign item_cmd  = tbrl_pkg::cmd_t'(item.cmd);
  assign item.ready = (ctrl.state == tbrl_pkg::ST_IDLE);
  assign item_fire = item.valid & item.ready;
  assign is_consume = (item_cmd == tbrl_pkg::CMD_CONSUME);

  assign result.valid          = (ctrl.state == tbrl_pkg::ST_OUT);
  assign result.granted        = granted_q;
  assign result.retry_after_ms = retry_q;
  assign result.level_now      = level;

  // divide step: shift the next dividend bit under the remainder
  assign trial = {rem, dvd[tbrl_pkg::NEED_W-1]};
  assign quot  = {dvd[tbrl_pkg::NEED_W-2:0], ~alu_borrow};

  // raise a burst write to the minimum capacity
  assign burst_wr = (cfg_data[tbrl_pkg::LEVEL_W-1:0] < tbrl_pkg::BURST_MIN)
                    ? tbrl_pkg::BURST_MIN : cfg_data[tbrl_pkg::LEVEL_W-1:0];

  assign stat.alu_borrow  = alu_borrow;
  assign stat.alu_zero    = alu_zero;
  assign stat.cool_active = cool_active;
  assign stat.rate_zero   = (rate == '0);

  tbrl_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_cmd    (item_cmd),
    .out_ready (result.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  tbrl_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .res    (alu_res),
    .borrow (alu_borrow),
    .zero   (alu_zero)
  );

  // select shared unit operands for the current step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.state)
      tbrl_pkg::ST_ELAPSED: begin
        alu_a   = tbrl_pkg::ALU_W'(now_q);
        alu_b   = tbrl_pkg::ALU_W'(last_time);
        alu_sub = 1'b1;
      end
      tbrl_pkg::ST_MUL: begin
        alu_a = acc;
        alu_b = mult[0] ? tbrl_pkg::ALU_W'(mcand) : '0;
      end
      tbrl_pkg::ST_CAP: begin
        alu_a   = acc;
        alu_b   = tbrl_pkg::ALU_W'(burst);
        alu_sub = 1'b1;
      end
      tbrl_pkg::ST_COOL: begin
        alu_a   = tbrl_pkg::ALU_W'(deadline);
        alu_b   = tbrl_pkg::ALU_W'(now_q);
        alu_sub = 1'b1;
      end
      tbrl_pkg::ST_NEED: begin
        alu_a   = tbrl_pkg::ALU_W'(need_q);
        alu_b   = tbrl_pkg::ALU_W'(level);
        alu_sub = 1'b1;
      end
      tbrl_pkg::ST_TAKE: begin
        alu_a   = tbrl_pkg::ALU_W'(level);
        alu_b   = tbrl_pkg::ALU_W'(need_q);
        alu_sub = 1'b1;
      end
      tbrl_pkg::ST_DIV: begin
        alu_a   = tbrl_pkg::ALU_W'(trial);
        alu_b   = tbrl_pkg::ALU_W'(rate);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // bucket state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      rate        <= tbrl_pkg::RATE_RESET;
      burst       <= tbrl_pkg::BURST_RESET;
      level       <= tbrl_pkg::BURST_RESET;
      last_time   <= '0;
      time_known  <= 1'b0;
      cool_active <= 1'b0;
      deadline    <= '0;
    end else begin
      case (ctrl.state)
        tbrl_pkg::ST_IDLE: begin
          if (item_fire) begin
            case (item_cmd)
              tbrl_pkg::CMD_COOLDOWN: begin
                cool_active <= 1'b1;
                deadline    <= item.until_ms;
              end
              tbrl_pkg::CMD_REFILL: begin
                level       <= burst;
                cool_active <= 1'b0;
                last_time   <= item.now_ms;
                time_known  <= 1'b1;
              end
              default: begin
              end
            endcase
          end
          // configuration writes land only while idle
          if (cfg_write) begin
            case (cfg_index)
              tbrl_pkg::REG_REFILL_RATE: rate <= cfg_data[tbrl_pkg::RATE_W-1:0];
              tbrl_pkg::REG_BURST_SIZE: begin
                burst <= burst_wr;
                if (level > burst_wr) level <= burst_wr;
              end
              default: begin
              end
            endcase
          end
        end
        tbrl_pkg::ST_CAP: begin
          // clamp the refilled level at burst
          level      <= alu_borrow ? acc[tbrl_pkg::LEVEL_W-1:0] : burst;
          last_time  <= now_q;
          time_known <= 1'b1;
        end
        tbrl_pkg::ST_COOL: begin
          if (!(cool_active && !alu_borrow && !alu_zero)) cool_active <= 1'b0;
        end
        tbrl_pkg::ST_TAKE: begin
          level <= alu_res[tbrl_pkg::LEVEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    case (ctrl.state)
      tbrl_pkg::ST_IDLE: begin
        if (item_fire) begin
          now_q     <= item.now_ms;
          need_q    <= {item.request_tokens, {tbrl_pkg::FRAC_BITS{1'b0}}};
          granted_q <= 1'b0;
          retry_q   <= '0;
        end
      end
      tbrl_pkg::ST_ELAPSED: begin
        // backward time or first item counts as zero elapsed
        if (time_known && !alu_borrow) begin
          mcand <= tbrl_pkg::MCAND_W'(alu_res[tbrl_pkg::TIME_W-1:0]);
        end else begin
          mcand <= '0;
        end
        mult <= rate;
        acc  <= tbrl_pkg::ALU_W'(level);
      end
      tbrl_pkg::ST_MUL: begin
        acc   <= alu_res;
        mcand <= {mcand[tbrl_pkg::MCAND_W-2:0], 1'b0};
        mult  <= {1'b0, mult[tbrl_pkg::RATE_W-1:1]};
      end
      tbrl_pkg::ST_COOL: begin
        if (cool_active && !alu_borrow && !alu_zero) begin
          retry_q <= (alu_res[tbrl_pkg::TIME_W-1:tbrl_pkg::RETRY_W] != '0)
                     ? '1 : alu_res[tbrl_pkg::RETRY_W-1:0];
        end
      end
      tbrl_pkg::ST_NEED: begin
        dvd <= alu_res[tbrl_pkg::NEED_W-1:0];
        rem <= '0;
        if (!alu_borrow && !alu_zero && rate == '0) retry_q <= tbrl_pkg::NO_RATE_WAIT_MS;
      end
      tbrl_pkg::ST_TAKE: begin
        granted_q <= 1'b1;
      end
      tbrl_pkg::ST_DIV: begin
        rem <= alu_borrow ? trial[tbrl_pkg::RATE_W-1:0] : alu_res[tbrl_pkg::RATE_W-1:0];
        dvd <= quot;
        if (ctrl.last_step) begin
          retry_q <= (quot[tbrl_pkg::NEED_W-1:tbrl_pkg::RETRY_W] != '0)
                     ? '1 : quot[tbrl_pkg::RETRY_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  `TBRL_ASSERT_IMP(a_level_within_burst, 1'b1, level <= burst)
  `TBRL_ASSERT_IMP(a_no_accept_with_result, result.valid, !item.ready)
  `TBRL_ASSERT_IMP(a_grant_has_no_wait, result.valid && result.granted, result.retry_after_ms == '0)
  `TBRL_ASSERT_NEXT(a_busy_next, item_fire, !item.ready && result.valid != $past(is_consume))

endmodule
